[rtl/power_meter_request_response_engine_macros.svh]
// assertion helpers used by the checker file
`ifndef POWER_METER_REQUEST_RESPONSE_ENGINE_MACROS_SVH
`define POWER_METER_REQUEST_RESPONSE_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PMRE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PMRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pmre_pkg.sv]
`default_nettype none
package pmre_pkg;

  localparam int unsigned REPLY_BYTES = 7;
  localparam int unsigned FRAME_MAX   = 8;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_RX    = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] KIND_VOLT   = 3'd0;
  localparam logic [2:0] KIND_CURR   = 3'd1;
  localparam logic [2:0] KIND_POWER  = 3'd2;
  localparam logic [2:0] KIND_ENERGY = 3'd3;
  localparam logic [2:0] KIND_ALARM  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_BADCODE = 2'd2;
  localparam logic [1:0] ST_BADSUM  = 2'd3;

  localparam logic RES_TX  = 1'b0;
  localparam logic RES_CPL = 1'b1;

  localparam logic CFG_DEV_ADDR = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  localparam logic [31:0] DEV_ADDR_RST = 32'hC0A8_0101;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

  localparam logic [7:0] CODE_BASE  = 8'hB0;
  localparam logic [7:0] CODE_ALARM = 8'hB5;
  localparam logic [7:0] REPLY_OFS  = 8'h10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  request_kind;
    logic [15:0] alarm_watts;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_type;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [1:0]  status;
    logic [2:0]  reading_kind;
    logic [22:0] reading_value;
    logic        alarm_flag;
  } out_item_t;

  function automatic logic [7:0] cmd_code(input logic [2:0] kind);
    cmd_code = (kind == KIND_ALARM) ? CODE_ALARM : (CODE_BASE + {5'd0, kind});
  endfunction

endpackage
`default_nettype wire

[rtl/power_meter_request_response_engine.sv]
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | in_data  (cmd, kind, watts, rx byte)
// out     | output    | out_valid / out_stall | out_data (tx byte or completion)
// cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// one item is taken per cycle while in_stall is low; a received byte or a tick is decoded in one pass
// between the item register and the result register.
// a start request loads a 6 or 8 beat frame into the output shift register; the next
// item that produces a result waits until that frame's last beat has left.
// items that produce no result pass without waiting on the output side.
// rst_n is synchronous and active low; it clears the handshake and protocol state.
// out_stall holds the current beat; a result item waiting in the item register stalls in.
`default_nettype none
module power_meter_request_response_engine
  import pmre_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam logic [3:0] FRAME_SHORT = 4'd6;
  localparam logic [3:0] FRAME_LONG  = 4'(FRAME_MAX);
  localparam logic [2:0] LAST_IDX    = 3'(REPLY_BYTES - 1);

  // configuration
  logic [31:0] dev_addr_r;
  logic [15:0] timeout_r;

  // item register
  logic     item_valid_r, item_valid_nxt;
  in_item_t item_r;

  // protocol state
  logic        awaiting_r, awaiting_nxt;
  logic [2:0]  pend_kind_r, pend_kind_nxt;
  logic [2:0]  rep_idx_r, rep_idx_nxt;
  logic [7:0]  rep_sum_r, rep_sum_nxt;
  logic        code_bad_r, code_bad_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [7:0]  pay_r [4];
  logic        pay_we;
  logic [1:0]  pay_sel;

  // output burst
  logic [3:0]  bst_cnt_r, bst_cnt_nxt;
  logic [7:0]  frame_r [FRAME_MAX];
  logic [7:0]  frame_nxt [FRAME_MAX];
  logic        cpl_r, cpl_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [22:0] value_r, value_nxt;
  logic        alarm_r, alarm_nxt;

  logic        out_take, burst_free, emit, proc;
  logic        start_ok, rx_live, rx_done, tick_live, tmo;
  logic [15:0] elapsed_inc;
  logic [7:0]  code, chk;
  logic [7:0]  fr [FRAME_MAX];
  logic [15:0] word;
  logic [22:0] decoded;
  logic [1:0]  rx_status;

  assign out_valid  = (bst_cnt_r != 4'd0);
  assign out_take   = out_valid && !out_stall;
  assign burst_free = (bst_cnt_r == 4'd0) || ((bst_cnt_r == 4'd1) && out_take);

  assign start_ok  = (item_r.cmd == CMD_START) && !awaiting_r &&
                     (item_r.request_kind <= KIND_ALARM);
  assign rx_live   = (item_r.cmd == CMD_RX) && awaiting_r;
  assign rx_done   = rx_live && (rep_idx_r >= LAST_IDX);
  assign tick_live = (item_r.cmd == CMD_TICK) && awaiting_r;
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign tmo       = tick_live && (elapsed_inc >= timeout_r);

  assign emit     = start_ok || rx_done || tmo;
  assign proc     = item_valid_r && (!emit || burst_free);
  assign in_stall = item_valid_r && !proc;
  assign item_valid_nxt = in_stall ? 1'b1 : in_valid;

  // frame bytes for a start request
  always_comb begin
    code = cmd_code(item_r.request_kind);
    fr[0] = code;
    fr[1] = dev_addr_r[31:24];
    fr[2] = dev_addr_r[23:16];
    fr[3] = dev_addr_r[15:8];
    fr[4] = dev_addr_r[7:0];
    chk = code + dev_addr_r[31:24] + dev_addr_r[23:16] + dev_addr_r[15:8] +
          dev_addr_r[7:0];
    if (item_r.request_kind == KIND_ALARM) begin
      chk   = chk + item_r.alarm_watts[15:8] + item_r.alarm_watts[7:0];
      fr[5] = item_r.alarm_watts[15:8];
      fr[6] = item_r.alarm_watts[7:0];
      fr[7] = chk;
    end else begin
      fr[5] = chk;
      fr[6] = 8'd0;
      fr[7] = 8'd0;
    end
  end

  // reading decode from the stored reply bytes
  always_comb begin
    word = {pay_r[0], pay_r[1]};
    case (pend_kind_r)
      KIND_VOLT, KIND_POWER: decoded = 23'(word) * 23'd10 + 23'(pay_r[2]);
      KIND_CURR:   decoded = 23'(pay_r[0]) * 23'd1000 + 23'(pay_r[1]) * 23'd10 +
                             23'(pay_r[2]);
      KIND_ENERGY: decoded = 23'(word) * 23'd100 + 23'(pay_r[2]);
      default:     decoded = 23'd0;
    endcase
    if (code_bad_r) begin
      rx_status = ST_BADCODE;
    end else if (item_r.rx_byte != rep_sum_r) begin
      rx_status = ST_BADSUM;
    end else begin
      rx_status = ST_OK;
    end
  end

  always_comb begin
    awaiting_nxt  = awaiting_r;
    pend_kind_nxt = pend_kind_r;
    rep_idx_nxt   = rep_idx_r;
    rep_sum_nxt   = rep_sum_r;
    code_bad_nxt  = code_bad_r;
    elapsed_nxt   = elapsed_r;
    pay_we        = 1'b0;
    pay_sel       = 2'(rep_idx_r - 3'd1);
    bst_cnt_nxt   = bst_cnt_r;
    cpl_nxt       = cpl_r;
    status_nxt    = status_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    alarm_nxt     = alarm_r;
    for (int i = 0; i < FRAME_MAX; i++) begin
      frame_nxt[i] = frame_r[i];
    end

    // shift out a taken beat
    if (out_take) begin
      bst_cnt_nxt = bst_cnt_r - 4'd1;
      for (int i = 0; i < FRAME_MAX - 1; i++) begin
        frame_nxt[i] = frame_r[i + 1];
      end
    end

    if (proc) begin
      if (start_ok) begin
        awaiting_nxt  = 1'b1;
        pend_kind_nxt = item_r.request_kind;
        rep_idx_nxt   = 3'd0;
        rep_sum_nxt   = 8'd0;
        code_bad_nxt  = 1'b0;
        elapsed_nxt   = 16'd0;
        bst_cnt_nxt   = (item_r.request_kind == KIND_ALARM) ? FRAME_LONG : FRAME_SHORT;
        cpl_nxt       = RES_TX;
        status_nxt    = ST_OK;
        kind_nxt      = 3'd0;
        value_nxt     = 23'd0;
        alarm_nxt     = 1'b0;
        for (int i = 0; i < FRAME_MAX; i++) begin
          frame_nxt[i] = fr[i];
        end
      end else if (rx_done) begin
        awaiting_nxt = 1'b0;
        rep_idx_nxt  = 3'd0;
        bst_cnt_nxt  = 4'd1;
        cpl_nxt      = RES_CPL;
        frame_nxt[0] = 8'd0;
        status_nxt   = rx_status;
        kind_nxt     = pend_kind_r;
        value_nxt    = (rx_status == ST_OK) ? decoded : 23'd0;
        alarm_nxt    = (rx_status == ST_OK) && (pend_kind_r == KIND_VOLT) && pay_r[3][0];
      end else if (rx_live) begin
        if (rep_idx_r == 3'd0) begin
          code_bad_nxt = (item_r.rx_byte != (cmd_code(pend_kind_r) - REPLY_OFS));
        end else if (rep_idx_r <= 3'd4) begin
          pay_we = 1'b1;
        end
        rep_sum_nxt = rep_sum_r + item_r.rx_byte;
        rep_idx_nxt = rep_idx_r + 3'd1;
      end else if (tick_live) begin
        elapsed_nxt = elapsed_inc;
        if (tmo) begin
          awaiting_nxt = 1'b0;
          rep_idx_nxt  = 3'd0;
          bst_cnt_nxt  = 4'd1;
          cpl_nxt      = RES_CPL;
          frame_nxt[0] = 8'd0;
          status_nxt   = ST_TIMEOUT;
          kind_nxt     = pend_kind_r;
          value_nxt    = 23'd0;
          alarm_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= DEV_ADDR_RST;
      timeout_r    <= TIMEOUT_RST;
      item_valid_r <= 1'b0;
      awaiting_r   <= 1'b0;
      pend_kind_r  <= 3'd0;
      rep_idx_r    <= 3'd0;
      rep_sum_r    <= 8'd0;
      code_bad_r   <= 1'b0;
      elapsed_r    <= 16'd0;
      bst_cnt_r    <= 4'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEV_ADDR) begin
          dev_addr_r <= cfg_wdata;
        end else begin
          timeout_r <= cfg_wdata[15:0];
        end
      end
      item_valid_r <= item_valid_nxt;
      awaiting_r   <= awaiting_nxt;
      pend_kind_r  <= pend_kind_nxt;
      rep_idx_r    <= rep_idx_nxt;
      rep_sum_r    <= rep_sum_nxt;
      code_bad_r   <= code_bad_nxt;
      elapsed_r    <= elapsed_nxt;
      bst_cnt_r    <= bst_cnt_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_data;
    end
    if (pay_we) begin
      pay_r[pay_sel] <= item_r.rx_byte;
    end
    for (int i = 0; i < FRAME_MAX; i++) begin
      frame_r[i] <= frame_nxt[i];
    end
    cpl_r    <= cpl_nxt;
    status_r <= status_nxt;
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
    alarm_r  <= alarm_nxt;
  end

  assign out_data.result_type   = cpl_r;
  assign out_data.tx_byte       = frame_r[0];
  assign out_data.last_byte     = (cpl_r == RES_TX) && (bst_cnt_r == 4'd1);
  assign out_data.status        = status_r;
  assign out_data.reading_kind  = kind_r;
  assign out_data.reading_value = value_r;
  assign out_data.alarm_flag    = alarm_r;

endmodule
`default_nettype wire

[rtl/pmre_checker.sv]
`default_nettype none
`include "power_meter_request_response_engine_macros.svh"
module pmre_checker
  import pmre_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data,
  input wire logic      cfg_we,
  input wire logic      cfg_index,
  input wire logic [31:0] cfg_wdata
);

  logic unused_ok;
  assign unused_ok = in_valid ^ in_stall ^ (^in_data) ^ cfg_we ^ cfg_index ^ (^cfg_wdata);

  // a held beat keeps its payload
  `PMRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_data), "out beat changed while stalled")

  // a frame beat that is not the last is followed by more frame
  `PMRE_ASSERT_NEXT(a_frame_cont, clk, rst_n,
    out_valid && !out_stall && (out_data.result_type == RES_TX) && !out_data.last_byte,
    out_valid && (out_data.result_type == RES_TX), "frame broken off before checksum")

  // a completion never marks a frame end nor carries a frame byte
  `PMRE_ASSERT_NOW(a_cpl_clean, clk, rst_n,
    out_valid && (out_data.result_type == RES_CPL),
    !out_data.last_byte && (out_data.tx_byte == 8'd0), "completion carries frame fields")

  // readings only come with an ok status
  `PMRE_ASSERT_NOW(a_value_ok, clk, rst_n,
    out_valid && ((out_data.reading_value != 23'd0) || out_data.alarm_flag),
    (out_data.result_type == RES_CPL) && (out_data.status == ST_OK),
    "reading on a failed completion")

endmodule

bind power_meter_request_response_engine pmre_checker u_pmre_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);
`default_nettype wire

[tb/power_meter_request_response_engine_tb.sv]
`timescale 1ns / 100ps

import pmre_pkg::*;

class meter_link_scoreboard;
  logic [31:0] dev_addr;
  logic [15:0] tmo_ticks;
  bit          awaiting;
  logic [2:0]  cur_kind;
  logic [2:0]  rx_pos;
  logic [7:0]  rx_sum;
  bit          code_bad;
  logic [7:0]  payload [4];
  logic [15:0] ticks;
  out_item_t   expected [$];
  int          errors;
  int          effective_beats;

  function new();
    dev_addr        = DEV_ADDR_RST;
    tmo_ticks       = TIMEOUT_RST;
    awaiting        = 1'b0;
    cur_kind        = KIND_VOLT;
    rx_pos          = '0;
    rx_sum          = '0;
    code_bad        = 1'b0;
    ticks           = '0;
    errors          = 0;
    effective_beats = 0;
    foreach (payload[i]) payload[i] = '0;
  endfunction

  function void write_reg(logic idx, logic [31:0] data);
    if (idx == CFG_DEV_ADDR) dev_addr = data;
    else tmo_ticks = data[15:0];
  endfunction

  function int pending();
    return expected.size();
  endfunction

  function logic [7:0] request_code(logic [2:0] kind);
    if (kind == KIND_ALARM) return CODE_ALARM;
    return CODE_BASE + {5'd0, kind};
  endfunction

  function logic [22:0] reading_of(logic [2:0] kind);
    int unsigned b1, b2, b3, v;
    b1 = payload[0];
    b2 = payload[1];
    b3 = payload[2];
    case (kind)
      KIND_VOLT, KIND_POWER: v = (b1 * 256 + b2) * 10 + b3;
      KIND_CURR:             v = b1 * 1000 + b2 * 10 + b3;
      KIND_ENERGY:           v = (b1 * 256 + b2) * 100 + b3;
      default:               v = 0;
    endcase
    return v[22:0];
  endfunction

  function void push_completion(logic [1:0] st);
    out_item_t r;
    r              = '0;
    r.result_type  = RES_CPL;
    r.status       = st;
    r.reading_kind = cur_kind;
    if (st == ST_OK) begin
      r.reading_value = reading_of(cur_kind);
      if (cur_kind == KIND_VOLT) r.alarm_flag = payload[3][0];
    end
    expected.push_back(r);
    awaiting = 1'b0;
    rx_pos   = '0;
  endfunction

  // update the protocol state for one accepted input beat and queue what it emits
  function void add_request_beat(in_item_t it);
    logic [7:0] frm [$];
    logic [7:0] csum;
    out_item_t  r;
    csum = '0;
    case (it.cmd)
      CMD_START: begin
        if (awaiting || it.request_kind > KIND_ALARM) return;
        frm.push_back(request_code(it.request_kind));
        frm.push_back(dev_addr[31:24]);
        frm.push_back(dev_addr[23:16]);
        frm.push_back(dev_addr[15:8]);
        frm.push_back(dev_addr[7:0]);
        if (it.request_kind == KIND_ALARM) begin
          frm.push_back(it.alarm_watts[15:8]);
          frm.push_back(it.alarm_watts[7:0]);
        end
        foreach (frm[i]) csum += frm[i];
        frm.push_back(csum);
        foreach (frm[i]) begin
          r             = '0;
          r.result_type = RES_TX;
          r.tx_byte     = frm[i];
          r.last_byte   = (i == frm.size() - 1);
          expected.push_back(r);
        end
        awaiting = 1'b1;
        cur_kind = it.request_kind;
        rx_pos   = '0;
        rx_sum   = '0;
        code_bad = 1'b0;
        ticks    = '0;
      end
      CMD_RX: begin
        if (!awaiting) return;
        if (rx_pos >= REPLY_BYTES - 1) begin
          // a bad reply code outranks a bad checksum
          if (code_bad) push_completion(ST_BADCODE);
          else if (it.rx_byte != rx_sum) push_completion(ST_BADSUM);
          else push_completion(ST_OK);
        end else begin
          if (rx_pos == 0) code_bad = (it.rx_byte != request_code(cur_kind) - REPLY_OFS);
          else if (rx_pos <= 4) payload[rx_pos - 1] = it.rx_byte;
          rx_sum += it.rx_byte;
          rx_pos += 1;
        end
      end
      CMD_TICK: begin
        if (!awaiting) return;
        if (ticks != 16'hFFFF) ticks += 1;
        if (ticks >= tmo_ticks) push_completion(ST_TIMEOUT);
      end
      default: return;
    endcase
    effective_beats++;
  endfunction

  function string show(out_item_t r);
    return $sformatf("type=%0d tx=%02h last=%0d st=%0d kind=%0d val=%0d alarm=%0d",
                     r.result_type, r.tx_byte, r.last_byte, r.status, r.reading_kind,
                     r.reading_value, r.alarm_flag);
  endfunction

  function void log_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (expected.size() == 0) begin
      log_error($sformatf("unexpected beat: %s", show(got)));
      return;
    end
    want = expected.pop_front();
    if (got.result_type !== want.result_type || got.tx_byte !== want.tx_byte ||
        got.last_byte !== want.last_byte || got.status !== want.status ||
        got.reading_kind !== want.reading_kind || got.reading_value !== want.reading_value ||
        got.alarm_flag !== want.alarm_flag)
      log_error($sformatf("mismatch\n  expected: %s\n  actual:   %s", show(want), show(got)));
  endfunction

  function void flush_leftovers();
    while (expected.size() != 0)
      log_error($sformatf("missing beat: %s", show(expected.pop_front())));
  endfunction
endclass

module power_meter_request_response_engine_tb;
  import pmre_pkg::*;

  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam int         RAND_BEATS = 280;

  typedef enum int {RP_GOOD, RP_BAD_CODE, RP_BAD_SUM, RP_BAD_BOTH} reply_shape_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  meter_link_scoreboard sb;
  int gap_pct;
  bit stall_on;
  int stall_hold;

  power_meter_request_response_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // receiver raises out_stall in random bursts while stall_on is set
  always @(negedge clk) begin
    if (!stall_on) begin
      out_stall <= 1'b0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 40);
    end else begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 16);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // called and returns at a falling edge; valid stays up for the next beat
  task automatic send_beat(input in_item_t it);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.add_request_beat(it);
    @(negedge clk);
  endtask

  task automatic start_req(input logic [2:0] kind, input logic [15:0] watts);
    in_item_t it;
    it              = in_item_t'($urandom);
    it.cmd          = CMD_START;
    it.request_kind = kind;
    it.alarm_watts  = watts;
    send_beat(it);
  endtask

  task automatic rx_in(input logic [7:0] b);
    in_item_t it;
    it         = in_item_t'($urandom);
    it.cmd     = CMD_RX;
    it.rx_byte = b;
    send_beat(it);
  endtask

  task automatic tick_in();
    in_item_t it;
    it     = in_item_t'($urandom);
    it.cmd = CMD_TICK;
    send_beat(it);
  endtask

  task automatic noop_in();
    in_item_t it;
    it     = in_item_t'($urandom);
    it.cmd = CMD_NONE;
    send_beat(it);
  endtask

  task automatic send_reply(input logic [2:0] kind, input reply_shape_t shape, input bit all_ones);
    logic [7:0] b [7];
    logic [7:0] csum;
    csum = '0;
    b[0] = sb.request_code(kind) - REPLY_OFS;
    if (shape == RP_BAD_CODE || shape == RP_BAD_BOTH) b[0] ^= 8'($urandom_range(1, 255));
    for (int i = 1; i < 6; i++) b[i] = all_ones ? 8'hFF : 8'($urandom);
    for (int i = 0; i < 6; i++) csum += b[i];
    b[6] = csum;
    if (shape == RP_BAD_SUM || shape == RP_BAD_BOTH) b[6] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < 7; i++) begin
      if ($urandom_range(0, 11) == 0) tick_in();
      rx_in(b[i]);
    end
  endtask

  task automatic settle_reply();
    while (sb.awaiting) rx_in(8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] addr, input logic [15:0] tmo);
    settle_reply();
    wait_drained();
    write_cfg(CFG_DEV_ADDR, addr);
    write_cfg(CFG_TIMEOUT, {16'($urandom), tmo});
  endtask

  function automatic logic [15:0] pick_watts();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_exchange();
    logic [2:0] kind;
    int         r;
    if ($urandom_range(0, 99) < 8) begin
      // junk while idle
      case ($urandom_range(0, 3))
        0: rx_in(8'($urandom));
        1: tick_in();
        2: noop_in();
        default: start_req(KIND_ALARM + 3'($urandom_range(1, 3)), pick_watts());
      endcase
    end
    kind = 3'($urandom_range(0, 4));
    start_req(kind, pick_watts());
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_reply(kind, RP_GOOD, $urandom_range(0, 9) == 0);
    end else if (r < 65) begin
      send_reply(kind, RP_BAD_CODE, 1'b0);
    end else if (r < 75) begin
      send_reply(kind, RP_BAD_SUM, 1'b0);
    end else if (r < 80) begin
      send_reply(kind, RP_BAD_BOTH, 1'b0);
    end else if (r < 90) begin
      // short reply, then let the timer run out if it is short
      repeat ($urandom_range(0, 6)) rx_in(8'($urandom));
      if (sb.tmo_ticks <= 64) while (sb.awaiting) tick_in();
    end else begin
      // requests and ticks while busy
      start_req(3'($urandom_range(0, 7)), pick_watts());
      if ($urandom_range(0, 1) == 0) tick_in();
      noop_in();
      send_reply(kind, RP_GOOD, 1'b0);
    end
    settle_reply();
  endtask

  initial begin
    int base;
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_DEV_ADDR;
    cfg_wdata  = '0;
    stall_on   = 1'b0;
    stall_hold = 0;
    gap_pct    = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed beats at reset settings
    stall_on = 1'b1;
    gap_pct  = 25;
    rx_in(8'hFF);
    tick_in();
    noop_in();
    start_req(KIND_ALARM + 3'd3, 16'hFFFF);
    start_req(KIND_ALARM, 16'hFFFF);
    start_req(KIND_VOLT, 16'h0000);
    send_reply(KIND_ALARM, RP_GOOD, 1'b0);
    start_req(KIND_ENERGY, 16'h0000);
    send_reply(KIND_ENERGY, RP_GOOD, 1'b1);
    settle_reply();

    // long timeout, run back to back
    set_config(32'h0000_0000, 16'd24);
    gap_pct = 0;
    start_req(KIND_CURR, 16'h0000);
    while (sb.awaiting) tick_in();

    base = sb.effective_beats;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       set_config(32'h0000_0000, 16'd1);
        1:       set_config(32'hFFFF_FFFF, 16'd0);
        default: set_config($urandom, 16'($urandom_range(2, 40)));
      endcase
      gap_pct  = (p == 4) ? 0 : $urandom_range(10, 40);
      stall_on = (p != 4);
      while (sb.effective_beats - base < (p + 1) * RAND_BEATS / 5) begin
        random_exchange();
        // hold off the sender until the receiver has caught up
        if (p == 2 && $urandom_range(0, 9) == 0) wait_drained();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
